[src/sact_pkg.sv]
`timescale 1ns / 1ps

package sact_pkg;

    localparam int LINES_DEF       = 256;
    localparam int ADDRESS_BITS_DEF = 48;

    localparam int STAMP_W     = 48;
    localparam int COUNT_W     = 32;
    localparam int OUT_FIELDS_W = 3 + 3 * COUNT_W;
    localparam int OUT_W       = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] REG_SET_BITS    = 2'd1;
    localparam logic [1:0] REG_WAY_BITS    = 2'd2;
    localparam logic [1:0] REG_LRU_MODE    = 2'd3;

    typedef struct packed {
        logic [5:0] offset_bits;
        logic [3:0] set_bits;
        logic [3:0] way_bits;
        logic       lru_mode;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_WRITE
    } back_state_t;

endpackage

[src/sact_ram.sv]
`timescale 1ns / 1ps

module sact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/sact_queue.sv]
`timescale 1ns / 1ps

module sact_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             ready,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (sact_pkg::QUEUE_DEPTH > 1) ? $clog2(sact_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(sact_pkg::QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(sact_pkg::QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(sact_pkg::QUEUE_DEPTH);

    logic [WIDTH-1:0] entry_reg [sact_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign ready    = (count_reg != FULL_CNT);
    assign valid    = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && ready;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/sact_front.sv]
`timescale 1ns / 1ps

module sact_front #(
    parameter int LINES = 256,
    parameter int ADDRESS_BITS = 48,
    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1,
    localparam int IN_W = ((ADDRESS_BITS + 7) / 8) * 8,
    localparam int ENTRY_W = 1 + ADDRESS_BITS + 2 * IDX_W
) (
    input  sact_pkg::cfg_t     cfg,
    input  logic               hold,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,
    input  logic               s_tuser,
    output logic               q_push,
    output logic [ENTRY_W-1:0] q_data,
    input  logic               q_ready
);

    localparam int LOG_L = $clog2(LINES + 1) - 1;
    localparam logic [4:0] CAP = 5'(LOG_L);

    logic                    is_write;
    logic [ADDRESS_BITS-1:0] addr;
    logic [ADDRESS_BITS-1:0] block;
    logic [ADDRESS_BITS-1:0] set_part;
    logic [ADDRESS_BITS-1:0] base_full;
    logic [ADDRESS_BITS-1:0] tag;
    logic [4:0]              wb, sb, set_cap;
    logic [IDX_W-1:0]        base;
    logic [IDX_W-1:0]        ways_m1;

    assign is_write = s_tuser;
    assign addr     = s_tdata[ADDRESS_BITS-1:0];

    always_comb
    begin
        wb = ({1'b0, cfg.way_bits} > CAP) ? CAP : {1'b0, cfg.way_bits};
        set_cap = CAP - wb;
        sb = ({1'b0, cfg.set_bits} > set_cap) ? set_cap : {1'b0, cfg.set_bits};
        block = addr >> cfg.offset_bits;
        set_part = block & ~({ADDRESS_BITS{1'b1}} << sb);
        tag = block >> sb;
        base_full = set_part << wb;
        base = base_full[IDX_W-1:0];
        ways_m1 = ~({IDX_W{1'b1}} << wb);
    end

    assign s_tready = q_ready && !hold;
    assign q_push   = s_tvalid && s_tready;
    assign q_data   = {is_write, tag, base, ways_m1};

endmodule

[src/sact_back.sv]
`timescale 1ns / 1ps

module sact_back #(
    parameter int LINES = 256,
    parameter int ADDRESS_BITS = 48,
    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1,
    localparam int ENTRY_W = 1 + ADDRESS_BITS + 2 * IDX_W,
    localparam int LINE_W = 1 + ADDRESS_BITS + sact_pkg::STAMP_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sact_pkg::cfg_t             cfg,
    input  logic                       q_valid,
    input  logic [ENTRY_W-1:0]         q_data,
    output logic                       q_pop,
    output logic                       ram_we,
    output logic [IDX_W-1:0]           ram_waddr,
    output logic [LINE_W-1:0]          ram_wdata,
    output logic                       ram_re,
    output logic [IDX_W-1:0]           ram_raddr,
    input  logic [LINE_W-1:0]          ram_rdata,
    output logic                       clearing,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [sact_pkg::OUT_W-1:0] m_tdata
);

    localparam int SW = sact_pkg::STAMP_W;
    localparam int CW = sact_pkg::COUNT_W;
    localparam logic [IDX_W-1:0] LAST_LINE = IDX_W'(LINES - 1);

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == {CW{1'b1}}) ? v : v + CW'(1);
    endfunction

    sact_pkg::back_state_t state_reg, state_next;

    logic [IDX_W-1:0]        clr_reg, clr_next;
    logic                    wr_flag_reg, wr_flag_next;
    logic [ADDRESS_BITS-1:0] tag_reg, tag_next;
    logic [IDX_W-1:0]        base_reg, base_next;
    logic [IDX_W-1:0]        ways_m1_reg, ways_m1_next;
    logic [IDX_W-1:0]        rd_w_reg, rd_w_next;
    logic                    issued_all_reg, issued_all_next;
    logic                    pend_reg, pend_next;
    logic [IDX_W-1:0]        eval_idx_reg, eval_idx_next;
    logic                    eval_last_reg, eval_last_next;
    logic                    have_empty_reg, have_empty_next;
    logic                    have_oldest_reg, have_oldest_next;
    logic [SW-1:0]           oldest_reg, oldest_next;
    logic [IDX_W-1:0]        victim_reg, victim_next;
    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        target_reg, target_next;
    logic [SW-1:0]           stamp_reg, stamp_next;
    logic [CW-1:0]           hits_reg, hits_next;
    logic [CW-1:0]           misses_reg, misses_next;
    logic [CW-1:0]           writes_reg, writes_next;
    logic                    out_valid_reg, out_valid_next;
    logic [sact_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    logic                    line_v;
    logic [ADDRESS_BITS-1:0] line_tag;
    logic [SW-1:0]           line_stamp;
    logic                    hit_now;
    logic                    can_out;

    assign line_v     = ram_rdata[LINE_W-1];
    assign line_tag   = ram_rdata[LINE_W-2:SW];
    assign line_stamp = ram_rdata[SW-1:0];
    assign can_out    = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        wr_flag_next     = wr_flag_reg;
        tag_next         = tag_reg;
        base_next        = base_reg;
        ways_m1_next     = ways_m1_reg;
        rd_w_next        = rd_w_reg;
        issued_all_next  = issued_all_reg;
        pend_next        = pend_reg;
        eval_idx_next    = eval_idx_reg;
        eval_last_next   = eval_last_reg;
        have_empty_next  = have_empty_reg;
        have_oldest_next = have_oldest_reg;
        oldest_next      = oldest_reg;
        victim_next      = victim_reg;
        hit_next         = hit_reg;
        target_next      = target_reg;
        stamp_next       = stamp_reg;
        hits_next        = hits_reg;
        misses_next      = misses_reg;
        writes_next      = writes_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        hit_now          = 1'b0;
        q_pop            = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = target_reg;
        ram_wdata        = {1'b1, tag_reg, stamp_reg};
        ram_re           = 1'b0;
        ram_raddr        = base_reg + rd_w_reg;

        unique case (state_reg)
            sact_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == LAST_LINE)
                begin
                    state_next = sact_pkg::ST_IDLE;
                end
            end

            sact_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop            = 1'b1;
                    ways_m1_next     = q_data[IDX_W-1:0];
                    base_next        = q_data[2*IDX_W-1:IDX_W];
                    tag_next         = q_data[2*IDX_W+ADDRESS_BITS-1:2*IDX_W];
                    wr_flag_next     = q_data[ENTRY_W-1];
                    rd_w_next        = '0;
                    issued_all_next  = 1'b0;
                    pend_next        = 1'b0;
                    have_empty_next  = 1'b0;
                    have_oldest_next = 1'b0;
                    hit_next         = 1'b0;
                    state_next       = sact_pkg::ST_LOOKUP;
                end
            end

            sact_pkg::ST_LOOKUP:
            begin
                if (!issued_all_reg)
                begin
                    ram_re          = 1'b1;
                    pend_next       = 1'b1;
                    eval_idx_next   = ram_raddr;
                    eval_last_next  = (rd_w_reg == ways_m1_reg);
                    issued_all_next = (rd_w_reg == ways_m1_reg);
                    rd_w_next       = rd_w_reg + IDX_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (!line_v)
                    begin
                        if (!have_empty_reg)
                        begin
                            have_empty_next = 1'b1;
                            victim_next     = eval_idx_reg;
                        end
                    end
                    else
                    begin
                        if (!have_empty_reg && (!have_oldest_reg || line_stamp < oldest_reg))
                        begin
                            have_oldest_next = 1'b1;
                            oldest_next      = line_stamp;
                            victim_next      = eval_idx_reg;
                        end
                        hit_now = (line_tag == tag_reg);
                    end
                    if (hit_now || eval_last_reg)
                    begin
                        hit_next    = hit_now;
                        target_next = hit_now ? eval_idx_reg : victim_next;
                        state_next  = sact_pkg::ST_WRITE;
                    end
                end
            end

            sact_pkg::ST_WRITE:
            begin
                if (can_out)
                begin
                    ram_we      = !hit_reg || cfg.lru_mode;
                    hits_next   = hit_reg ? sat_inc(hits_reg) : hits_reg;
                    misses_next = hit_reg ? misses_reg : sat_inc(misses_reg);
                    writes_next = wr_flag_reg ? sat_inc(writes_reg) : writes_reg;
                    stamp_next  = stamp_reg + SW'(1);
                    out_valid_next = 1'b1;
                    out_data_next  = sact_pkg::OUT_W'({writes_next, misses_next, hits_next,
                                                       wr_flag_reg, !hit_reg, hit_reg});
                    state_next  = sact_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sact_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sact_pkg::ST_CLEAR;
            clr_reg         <= '0;
            issued_all_reg  <= 1'b0;
            pend_reg        <= 1'b0;
            have_empty_reg  <= 1'b0;
            have_oldest_reg <= 1'b0;
            hit_reg         <= 1'b0;
            stamp_reg       <= '0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            writes_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            issued_all_reg  <= issued_all_next;
            pend_reg        <= pend_next;
            have_empty_reg  <= have_empty_next;
            have_oldest_reg <= have_oldest_next;
            hit_reg         <= hit_next;
            stamp_reg       <= stamp_next;
            hits_reg        <= hits_next;
            misses_reg      <= misses_next;
            writes_reg      <= writes_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_flag_reg   <= wr_flag_next;
        tag_reg       <= tag_next;
        base_reg      <= base_next;
        ways_m1_reg   <= ways_m1_next;
        rd_w_reg      <= rd_w_next;
        eval_idx_reg  <= eval_idx_next;
        eval_last_reg <= eval_last_next;
        oldest_reg    <= oldest_next;
        victim_reg    <= victim_next;
        target_reg    <= target_next;
        out_data_reg  <= out_data_next;
    end

    assign clearing = (state_reg == sact_pkg::ST_CLEAR);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[src/set_assoc_cache_tag_model.sv]
// Flow: an accepted word enters a two-word queue, from which the lookup sequencer pops it
// when idle; it reads the ways of the set from the line memory until the first hit, or all
// ways of the set on a miss, then updates the line on a miss (or on a hit in LRU mode) and
// registers the result, waiting while the output is stalled. It finishes one word before it
// pops the next. Reset: asynchronous and active low; afterwards a clearing pass empties the
// line memory, and no word is accepted until it completes.
`timescale 1ns / 1ps

module set_assoc_cache_tag_model #(
    parameter int LINES = sact_pkg::LINES_DEF,
    parameter int ADDRESS_BITS = sact_pkg::ADDRESS_BITS_DEF,
    localparam int IN_W = ((ADDRESS_BITS + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: address, zero padding.
    input  logic [IN_W-1:0]                 s_axis_tdata,
    // Fields from bit 0: operation.
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: hit, memory_read, memory_write, hit_total, miss_total,
    // write_total, zero padding.
    output logic [sact_pkg::OUT_W-1:0]      m_axis_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sact_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sact_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sact_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int IDX_W   = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int ENTRY_W = 1 + ADDRESS_BITS + 2 * IDX_W;
    localparam int LINE_W  = 1 + ADDRESS_BITS + sact_pkg::STAMP_W;
    localparam int DW      = sact_pkg::CFG_DATA_W;

    sact_pkg::cfg_t     cfg_reg, cfg_next;
    logic [1:0]         reg_idx;
    logic               cfg_wr;

    logic               q_push, q_ready, q_pop, q_valid;
    logic [ENTRY_W-1:0] q_in, q_out;
    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [LINE_W-1:0]  ram_wdata, ram_rdata;
    logic               clearing;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (reg_idx)
            sact_pkg::REG_OFFSET_BITS:
            begin
                prdata = DW'(cfg_reg.offset_bits);
                if (cfg_wr)
                begin
                    cfg_next.offset_bits = pwdata[5:0];
                end
            end
            sact_pkg::REG_SET_BITS:
            begin
                prdata = DW'(cfg_reg.set_bits);
                if (cfg_wr)
                begin
                    cfg_next.set_bits = pwdata[3:0];
                end
            end
            sact_pkg::REG_WAY_BITS:
            begin
                prdata = DW'(cfg_reg.way_bits);
                if (cfg_wr)
                begin
                    cfg_next.way_bits = pwdata[3:0];
                end
            end
            sact_pkg::REG_LRU_MODE:
            begin
                prdata = DW'(cfg_reg.lru_mode);
                if (cfg_wr)
                begin
                    cfg_next.lru_mode = pwdata[0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sact_front #(
        .LINES        (LINES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .cfg      (cfg_reg),
        .hold     (clearing),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_ready  (q_ready)
    );

    sact_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    sact_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINES)
    ) u_lines (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sact_back #(
        .LINES        (LINES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .clearing  (clearing),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> !clearing)
        else $error("A word was accepted during the clearing pass.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] != m_axis_tdata[1]))
        else $error("A result is not exactly one of hit and fetch.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && !clearing) |=> !ram_we)
        else $error("More than one line update for a single word.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> clearing)
        else $error("Line memory read and updated in the same cycle.");
`endif

endmodule
